>>> rtl/core/md5_byte_stream_hasher_macros.svh
// Assertion macros for the MD5 byte stream hasher.
// Used by the port checker; needs nothing else.
`ifndef MD5_BYTE_STREAM_HASHER_MACROS_SVH
`define MD5_BYTE_STREAM_HASHER_MACROS_SVH

// same-cycle implication, checked outside reset
`define MD5BSH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define MD5BSH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/md5bsh_pkg.sv
// Shared types, constants and round tables for the MD5 byte stream hasher.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package md5bsh_pkg;

	typedef logic [3:0][31:0] word4_t;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic CMD_DATA   = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PAD   = 6'b000010,
		ST_LOAD  = 6'b000100,
		ST_ROUND = 6'b001000,
		ST_ADD   = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	// controls from the sequencer to the round unit
	typedef struct packed {
		logic       load;
		logic       step;
		logic [5:0] rnd;
	} rnd_ctl_t;

	function automatic word4_t iv_words();
		word4_t w;
		w[0] = IV_A;
		w[1] = IV_B;
		w[2] = IV_C;
		w[3] = IV_D;
		return w;
	endfunction

	// message word used by a round
	function automatic logic [3:0] msg_index(input logic [5:0] r);
		logic [3:0] g;
		case (r[5:4])
			2'd0:    g = r[3:0];
			2'd1:    g = 4'(5 * r[3:0] + 1);
			2'd2:    g = 4'(3 * r[3:0] + 5);
			2'd3:    g = 4'(7 * r[3:0]);
			default: g = r[3:0];
		endcase
		return g;
	endfunction

	function automatic logic [4:0] rot_amount(input logic [5:0] r);
		logic [4:0] s;
		case ({r[5:4], r[1:0]})
			4'd0:    s = 5'd7;
			4'd1:    s = 5'd12;
			4'd2:    s = 5'd17;
			4'd3:    s = 5'd22;
			4'd4:    s = 5'd5;
			4'd5:    s = 5'd9;
			4'd6:    s = 5'd14;
			4'd7:    s = 5'd20;
			4'd8:    s = 5'd4;
			4'd9:    s = 5'd11;
			4'd10:   s = 5'd16;
			4'd11:   s = 5'd23;
			4'd12:   s = 5'd6;
			4'd13:   s = 5'd10;
			4'd14:   s = 5'd15;
			4'd15:   s = 5'd21;
			default: s = 5'd7;
		endcase
		return s;
	endfunction

	function automatic logic [31:0] round_const(input logic [5:0] r);
		logic [31:0] k;
		case (r)
			6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	// word holding the bytes already gathered, the pad byte, then zeros
	function automatic logic [31:0] pad_word(input logic [23:0] gath, input logic [1:0] sel);
		logic [31:0] w;
		case (sel)
			2'd0:    w = {24'h0, PAD_BYTE};
			2'd1:    w = {16'h0, PAD_BYTE, gath[7:0]};
			2'd2:    w = {8'h0, PAD_BYTE, gath[15:0]};
			2'd3:    w = {PAD_BYTE, gath[23:0]};
			default: w = {24'h0, PAD_BYTE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/md5bsh_block_mem.sv
// Block store: 16 x 32-bit message words, one write and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module md5bsh_block_mem (
	input  wire logic        clk,
	input  wire logic        we,
	input  wire logic [3:0]  waddr,
	input  wire logic [31:0] wdata,
	input  wire logic [3:0]  raddr,
	output logic      [31:0] rdata
);

	logic [31:0] mem [16];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/core/md5bsh_round.sv
// MD5 round unit: working registers A..D and one round step per cycle while step is set.
// Depends on md5bsh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module md5bsh_round (
	input  wire logic                clk,
	input  wire md5bsh_pkg::rnd_ctl_t ctl,
	input  wire md5bsh_pkg::word4_t   chain,
	input  wire logic [31:0]         msg,
	output md5bsh_pkg::word4_t        work
);

	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] f;
	logic [31:0] sum;
	logic [63:0] dbl;
	logic [31:0] rot;
	logic [4:0]  sh;

	always_comb begin
		case (ctl.rnd[5:4])
			2'd0:    f = d_q ^ (b_q & (c_q ^ d_q));
			2'd1:    f = c_q ^ (d_q & (b_q ^ c_q));
			2'd2:    f = b_q ^ c_q ^ d_q;
			2'd3:    f = c_q ^ (b_q | ~d_q);
			default: f = b_q ^ c_q ^ d_q;
		endcase
		sh  = md5bsh_pkg::rot_amount(ctl.rnd);
		sum = a_q + f + md5bsh_pkg::round_const(ctl.rnd) + msg;
		dbl = {sum, sum} << sh;
		rot = dbl[63:32];
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_q <= chain[0];
			b_q <= chain[1];
			c_q <= chain[2];
			d_q <= chain[3];
		end else if (ctl.step) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= b_q + rot;
		end
	end

	assign work[0] = a_q;
	assign work[1] = b_q;
	assign work[2] = c_q;
	assign work[3] = d_q;

endmodule

`default_nettype wire

>>> rtl/core/md5_byte_stream_hasher.sv
// MD5 byte stream hasher: top level with byte packing, padding sequencer and chain.
// Depends on md5bsh_pkg, md5bsh_block_mem, md5bsh_round.
//
// Input stream: s_tdata carries one message byte, s_tuser is the command
// (0 = append byte, 1 = finish). Output stream: m_tdata carries the 128-bit
// digest, word A in the lowest 32 bits.
// Bytes are taken one per cycle while s_tready is high. The 64th byte of a
// block starts the compression, which keeps s_tready low while it loads the
// working registers, runs 64 rounds through the shared round unit fed by the
// block store's read port and adds into the chain.
// A finish writes the pad word and the zero words up to the end of the block,
// with the bit length in the last two words of the last block, compresses,
// and when 8 or fewer bytes of room remained runs a second 16-word pad and
// compression. Once the output is free, the done state moves the digest into
// the output register, sets it valid and restarts the chain from the initial
// constants. Reset sets the chain to the initial constants and the byte count
// to zero; the block store needs no clearing. A stalled receiver holds the
// digest; bytes keep flowing, and only a later finish waits for the digest to go.
`timescale 1ns / 1ps
`default_nettype none

module md5_byte_stream_hasher (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,  // [7:0] data_byte
	input  wire logic         s_tuser,  // [0] cmd
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic      [127:0] m_tdata   // digest_word0..digest_word3, low first
);

	md5bsh_pkg::state_t   state_q;
	md5bsh_pkg::word4_t   chain_q;
	md5bsh_pkg::word4_t   work;
	md5bsh_pkg::rnd_ctl_t rctl;

	logic [60:0]  count_q;
	logic [23:0]  gath_q;
	logic [1:0]   sel_q;
	logic [3:0]   widx_q;
	logic         first_q;
	logic         len_q;
	logic         fin_q;
	logic [63:0]  bits_q;
	logic [5:0]   rnd_q;
	logic         out_valid_q;
	logic [127:0] out_q;

	logic        mem_we;
	logic [3:0]  mem_waddr;
	logic [31:0] mem_wdata;
	logic [3:0]  mem_raddr;
	logic [31:0] mem_rdata;

	logic [5:0] pos;
	logic       acc;
	logic       out_free;

	assign pos      = count_q[5:0];
	assign s_tready = (state_q == md5bsh_pkg::ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	// Writes happen only while taking bytes or padding; read data is used only while
	// compressing, so the sequencer alone keeps the two apart.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = widx_q;
		mem_wdata = 32'h0;
		if (state_q == md5bsh_pkg::ST_IDLE) begin
			mem_we    = acc && (s_tuser == md5bsh_pkg::CMD_DATA) && (pos[1:0] == 2'd3);
			mem_waddr = pos[5:2];
			mem_wdata = {s_tdata, gath_q};
		end else if (state_q == md5bsh_pkg::ST_PAD) begin
			mem_we = 1'b1;
			if (first_q) begin
				mem_wdata = md5bsh_pkg::pad_word(gath_q, sel_q);
			end else if (len_q && widx_q == 4'd14) begin
				mem_wdata = bits_q[31:0];
			end else if (len_q && widx_q == 4'd15) begin
				mem_wdata = bits_q[63:32];
			end
		end
		mem_raddr = md5bsh_pkg::msg_index((state_q == md5bsh_pkg::ST_ROUND) ?
			6'(rnd_q + 6'd1) : 6'd0);
	end

	assign rctl.load = (state_q == md5bsh_pkg::ST_LOAD);
	assign rctl.step = (state_q == md5bsh_pkg::ST_ROUND);
	assign rctl.rnd  = rnd_q;

	md5bsh_block_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	md5bsh_round u_round (
		.clk   (clk),
		.ctl   (rctl),
		.chain (chain_q),
		.msg   (mem_rdata),
		.work  (work)
	);

	// byte gathering and padding registers
	always_ff @(posedge clk) begin
		if (acc && s_tuser == md5bsh_pkg::CMD_DATA) begin
			case (pos[1:0])
				2'd0:    gath_q[7:0]   <= s_tdata;
				2'd1:    gath_q[15:8]  <= s_tdata;
				2'd2:    gath_q[23:16] <= s_tdata;
				default: gath_q        <= gath_q;
			endcase
		end
		if (acc && s_tuser == md5bsh_pkg::CMD_FINISH) begin
			sel_q  <= pos[1:0];
			bits_q <= {count_q, 3'b000};
		end
		if (state_q == md5bsh_pkg::ST_DONE && out_free) begin
			out_q <= chain_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= md5bsh_pkg::ST_IDLE;
			chain_q     <= md5bsh_pkg::iv_words();
			count_q     <= '0;
			widx_q      <= '0;
			first_q     <= 1'b0;
			len_q       <= 1'b0;
			fin_q       <= 1'b0;
			rnd_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == md5bsh_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				md5bsh_pkg::ST_IDLE: begin
					if (acc) begin
						if (s_tuser == md5bsh_pkg::CMD_DATA) begin
							count_q <= count_q + 61'd1;
							fin_q   <= 1'b0;
							if (pos == 6'd63) begin
								state_q <= md5bsh_pkg::ST_LOAD;
							end
						end else begin
							count_q <= '0;
							widx_q  <= pos[5:2];
							first_q <= 1'b1;
							len_q   <= (pos[5:3] != 3'd7);
							fin_q   <= 1'b1;
							state_q <= md5bsh_pkg::ST_PAD;
						end
					end
				end
				md5bsh_pkg::ST_PAD: begin
					first_q <= 1'b0;
					widx_q  <= widx_q + 4'd1;
					if (widx_q == 4'd15) begin
						state_q <= md5bsh_pkg::ST_LOAD;
					end
				end
				md5bsh_pkg::ST_LOAD: begin
					rnd_q   <= '0;
					state_q <= md5bsh_pkg::ST_ROUND;
				end
				md5bsh_pkg::ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= md5bsh_pkg::ST_ADD;
					end
				end
				md5bsh_pkg::ST_ADD: begin
					chain_q[0] <= chain_q[0] + work[0];
					chain_q[1] <= chain_q[1] + work[1];
					chain_q[2] <= chain_q[2] + work[2];
					chain_q[3] <= chain_q[3] + work[3];
					if (!fin_q) begin
						state_q <= md5bsh_pkg::ST_IDLE;
					end else if (!len_q) begin
						// length did not fit: one more all-pad block
						len_q   <= 1'b1;
						widx_q  <= '0;
						state_q <= md5bsh_pkg::ST_PAD;
					end else begin
						state_q <= md5bsh_pkg::ST_DONE;
					end
				end
				md5bsh_pkg::ST_DONE: begin
					if (out_free) begin
						chain_q <= md5bsh_pkg::iv_words();
						fin_q   <= 1'b0;
						state_q <= md5bsh_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= md5bsh_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/md5bsh_checker.sv
// Port-level checker for the MD5 byte stream hasher, bound to the top level.
// Depends on md5_byte_stream_hasher_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "md5_byte_stream_hasher_macros.svh"

module md5bsh_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic         s_tuser,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [127:0] m_tdata
);

	`MD5BSH_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "digest dropped or changed while stalled")

	// a finish request always takes the block busy for padding
	`MD5BSH_ASSERT_NXT(a_finish_busy, clk, arst_n, s_tvalid && s_tready && s_tuser, !s_tready && !$rose(m_tvalid), "finish did not start padding")

	// a new digest appears only after a busy cycle
	`MD5BSH_ASSERT_IMP(a_digest_from_busy, clk, arst_n, $rose(m_tvalid), !$past(s_tready), "digest appeared without a finish")

	// a byte request never produces a digest on the next cycle
	`MD5BSH_ASSERT_NXT(a_byte_no_digest, clk, arst_n, s_tvalid && s_tready && !s_tuser, !$rose(m_tvalid), "byte request produced a digest")

endmodule

bind md5_byte_stream_hasher md5bsh_checker u_md5bsh_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
